// ===== rtl/core/oaa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit angle advance package
// Shared constants, types and the arctangent table of the angle core.
// ----------------------------------------------------------------------------
package oaa_pkg;

	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int ANG_W = 26;
	localparam int CFG_W = 32;
	localparam int DT_W  = 24;
	localparam int IDX_W = 2;

	localparam int CW    = 36;
	localparam int ZW    = 34;
	localparam int MUL_W = 34;
	localparam int DIV_W = 64;
	localparam int ROOT_STEPS = 32;

	localparam logic [IDX_W-1:0] CFG_MAJOR = 2'd0;
	localparam logic [IDX_W-1:0] CFG_MINOR = 2'd1;
	localparam logic [IDX_W-1:0] CFG_RATE  = 2'd2;

	localparam logic [CFG_W-1:0] MAJOR_RST = 32'd65536;
	localparam logic [CFG_W-1:0] MINOR_RST = 32'd65536;

	localparam logic signed [26:0] FULL_DEG    = 27'sd23592960;
	localparam logic signed [26:0] HALF_DEG    = 27'sd11796480;
	localparam logic signed [26:0] QUARTER_DEG = 27'sd5898240;
	localparam logic signed [ANG_W-1:0] ANG_LIM = 26'sd23592959;

	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 36'sd652032874;
	localparam logic [47:0] DEG_TO_RAD_Q30 = 48'd18740330;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDIV,
		ST_RR,
		ST_FROOT,
		ST_CWAIT,
		ST_RC,
		ST_TH,
		ST_SH,
		ST_DROOT,
		ST_GROOT,
		ST_P,
		ST_STEP,
		ST_MOD,
		ST_OUT
	} oaa_state_t;

	typedef enum logic [1:0] {
		CP_IDLE,
		CP_SCALE,
		CP_ROT
	} cdc_phase_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/orbit_angle_advance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit angle advance core
// Advances a stored orbital angle once per time step request, using shared
// serial divide, multiply and root units and a serial CORDIC.
// ----------------------------------------------------------------------------
// Each request runs three divisions, five multiplications and up to three roots in turn;
// the ratio division is skipped with a zero minor axis and the first root when the axis
// ratio is at most one.
// One request at a time: the next is accepted in the cycle after the result is stored.
// Reset clears the angle to zero and loads major and minor axis 1.0, rate 0.
module orbit_angle_advance_core #(
	parameter int CORDIC_STEPS  = oaa_pkg::CORDIC_STEPS_DEF,
	parameter int FRACTION_BITS = oaa_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [oaa_pkg::IDX_W-1:0]         cfg_index,
	input  logic [oaa_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [oaa_pkg::DT_W-1:0]          time_step,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [oaa_pkg::ANG_W-1:0]  new_angle
);

	localparam int FB = FRACTION_BITS;
	localparam int UP = (FB >= 16) ? FB - 16 : 0;
	localparam int DN = (FB < 16) ? 16 - FB : 0;
	localparam int SF = 30 - FB;
	localparam int MW = oaa_pkg::MUL_W;
	localparam int CW = oaa_pkg::CW;
	localparam int AW = oaa_pkg::ANG_W;
	localparam logic [31:0] R_ONE = 32'd1 << FB;
	localparam logic [31:0] R_MAX = 32'd255 << FB;
	localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FB);

	oaa_pkg::oaa_state_t state_q, state_d;
	logic go_q, cdone_q, out_valid_q, accept;
	logic [31:0] major_q, minor_q, rate_q, rate_abs;
	logic signed [AW-1:0] orbit_q, out_q, res_w;

	logic [oaa_pkg::DT_W-1:0] dt_q;
	logic [31:0] r_q, f_q, g_q;
	logic [63:0] r2_q, sq_q, p_q;
	logic [32:0] d_q;
	logic [MW-1:0] th_q, sh_q;
	logic signed [63:0] sum_q, sum_w, rc_w, t_w, th_w, sh_w;
	logic [63:0] sum_abs;
	logic [24:0] rem_q;

	logic mul_start, mul_done, div_start, div_done, root_start, root_done, cor_done;
	logic [MW-1:0] mul_a, mul_b;
	logic [63:0] mul_prod, div_dvd, div_dsr, div_quo, div_rem, root_v;
	logic [31:0] root_res;
	logic signed [CW-1:0] sin_w, cos_w, s_w, c_w, c_abs;
	logic c_neg;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == oaa_pkg::ST_IDLE);
	assign rate_abs = rate_q[31] ? 32'(-rate_q) : rate_q;

	assign s_w = sin_w >>> SF;
	assign c_w = cos_w >>> SF;
	assign c_neg = c_w[CW-1];
	assign c_abs = c_neg ? -c_w : c_w;
	assign rc_w = c_neg ? -$signed(mul_prod) : $signed(mul_prod);
	assign t_w = (rc_w >>> FB) + $signed(64'(f_q));
	assign th_w = (t_w >>> 1) < 0 ? -(t_w >>> 1) : (t_w >>> 1);
	assign sh_w = 64'(s_w >>> 1) < 0 ? -64'(s_w >>> 1) : 64'(s_w >>> 1);
	assign sum_w = 64'(orbit_q) + (rate_q[31] ? -$signed(div_quo) : $signed(div_quo));
	assign sum_abs = sum_q[63] ? 64'(-sum_q) : 64'(sum_q);
	assign res_w = sum_q[63] ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			oaa_pkg::ST_IDLE:
				if (accept) state_d = (minor_q == '0) ? oaa_pkg::ST_RR : oaa_pkg::ST_RDIV;
			oaa_pkg::ST_RDIV:  if (div_done) state_d = oaa_pkg::ST_RR;
			oaa_pkg::ST_RR:
				if (mul_done) state_d = (mul_prod > ONE_SQ) ? oaa_pkg::ST_FROOT : oaa_pkg::ST_CWAIT;
			oaa_pkg::ST_FROOT: if (root_done) state_d = oaa_pkg::ST_CWAIT;
			oaa_pkg::ST_CWAIT: if (cdone_q) state_d = oaa_pkg::ST_RC;
			oaa_pkg::ST_RC:    if (mul_done) state_d = oaa_pkg::ST_TH;
			oaa_pkg::ST_TH:    if (mul_done) state_d = oaa_pkg::ST_SH;
			oaa_pkg::ST_SH:    if (mul_done) state_d = oaa_pkg::ST_DROOT;
			oaa_pkg::ST_DROOT: if (root_done) state_d = oaa_pkg::ST_GROOT;
			oaa_pkg::ST_GROOT: if (root_done) state_d = oaa_pkg::ST_P;
			oaa_pkg::ST_P:     if (mul_done) state_d = oaa_pkg::ST_STEP;
			oaa_pkg::ST_STEP:  if (div_done) state_d = oaa_pkg::ST_MOD;
			oaa_pkg::ST_MOD:   if (div_done) state_d = oaa_pkg::ST_OUT;
			oaa_pkg::ST_OUT:   if (!out_valid_q || out_ready) state_d = oaa_pkg::ST_IDLE;
			default:           state_d = oaa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		root_start = 1'b0;
		mul_a = MW'(r_q);
		mul_b = MW'(r_q);
		div_dvd = 64'(major_q) << FB;
		div_dsr = 64'(minor_q);
		root_v = r2_q - ONE_SQ;
		case (state_q)
			oaa_pkg::ST_RDIV:  div_start = go_q;
			oaa_pkg::ST_RR:    mul_start = go_q;
			oaa_pkg::ST_FROOT: root_start = go_q;
			oaa_pkg::ST_RC: begin
				mul_start = go_q;
				mul_b = c_abs[MW-1:0];
			end
			oaa_pkg::ST_TH: begin
				mul_start = go_q;
				mul_a = th_q;
				mul_b = th_q;
			end
			oaa_pkg::ST_SH: begin
				mul_start = go_q;
				mul_a = sh_q;
				mul_b = sh_q;
			end
			oaa_pkg::ST_DROOT: begin
				root_start = go_q;
				root_v = sq_q;
			end
			oaa_pkg::ST_GROOT: begin
				root_start = go_q;
				root_v = 64'(d_q) << FB;
			end
			oaa_pkg::ST_P: begin
				mul_start = go_q;
				mul_a = MW'(rate_abs);
				mul_b = MW'(dt_q);
			end
			oaa_pkg::ST_STEP: begin
				div_start = go_q;
				div_dvd = p_q << UP;
				div_dsr = 64'(g_q) << DN;
			end
			oaa_pkg::ST_MOD: begin
				div_start = go_q;
				div_dvd = sum_abs;
				div_dsr = 64'(oaa_pkg::FULL_DEG);
			end
			default: mul_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaa_pkg::ST_IDLE;
			go_q <= 1'b0;
			cdone_q <= 1'b0;
			out_valid_q <= 1'b0;
			major_q <= oaa_pkg::MAJOR_RST;
			minor_q <= oaa_pkg::MINOR_RST;
			rate_q <= '0;
			orbit_q <= '0;
		end else begin
			state_q <= state_d;
			go_q <= (state_d != state_q) && (state_d != oaa_pkg::ST_IDLE);
			if (accept) cdone_q <= 1'b0;
			else if (cor_done) cdone_q <= 1'b1;
			if (cfg_write) begin
				case (cfg_index)
					oaa_pkg::CFG_MAJOR: major_q <= cfg_data;
					oaa_pkg::CFG_MINOR: minor_q <= cfg_data;
					oaa_pkg::CFG_RATE:  rate_q <= cfg_data;
					default:            rate_q <= rate_q;
				endcase
			end
			if (state_q == oaa_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				orbit_q <= res_w;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q <= time_step;
			r_q <= R_ONE;
		end
		case (state_q)
			oaa_pkg::ST_RDIV:
				if (div_done) r_q <= (div_quo > 64'(R_MAX)) ? R_MAX : div_quo[31:0];
			oaa_pkg::ST_RR:
				if (mul_done) begin
					r2_q <= mul_prod;
					f_q <= '0;
				end
			oaa_pkg::ST_FROOT: if (root_done) f_q <= root_res;
			oaa_pkg::ST_RC:
				if (mul_done) begin
					th_q <= th_w[MW-1:0];
					sh_q <= sh_w[MW-1:0];
				end
			oaa_pkg::ST_TH:    if (mul_done) sq_q <= mul_prod;
			oaa_pkg::ST_SH:    if (mul_done) sq_q <= sq_q + mul_prod;
			oaa_pkg::ST_DROOT:
				if (root_done) d_q <= (root_res == '0) ? 33'd1 : {root_res, 1'b0};
			oaa_pkg::ST_GROOT: if (root_done) g_q <= root_res;
			oaa_pkg::ST_P:     if (mul_done) p_q <= mul_prod;
			oaa_pkg::ST_STEP:  if (div_done) sum_q <= sum_w;
			oaa_pkg::ST_MOD:   if (div_done) rem_q <= div_rem[24:0];
			oaa_pkg::ST_OUT:
				if (!out_valid_q || out_ready) out_q <= res_w;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign new_angle = out_q;

	oaa_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.angle(orbit_q),
		.done(cor_done),
		.sine(sin_w),
		.cosine(cos_w)
	);

	oaa_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.product(mul_prod)
	);

	oaa_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dsr),
		.done(div_done),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	oaa_root u_root (
		.clk(clk),
		.arst_n(arst_n),
		.start(root_start),
		.value(root_v),
		.done(root_done),
		.root(root_res)
	);

	a_go_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> state_q != oaa_pkg::ST_IDLE)
		else $error("unit launch flagged while idle");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == oaa_pkg::ST_RDIV || state_q == oaa_pkg::ST_RR))
		else $error("request did not start the ratio computation");

	a_cordic_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == oaa_pkg::ST_RC |-> cdone_q)
		else $error("cosine used before the rotation finished");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (new_angle <= oaa_pkg::ANG_LIM && new_angle >= -oaa_pkg::ANG_LIM))
		else $error("result angle out of range");

	a_angle_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> orbit_q == new_angle)
		else $error("stored angle differs from the pending result");

endmodule

// ===== rtl/core/oaa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module oaa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [oaa_pkg::DIV_W-1:0] dividend,
	input  logic [oaa_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [oaa_pkg::DIV_W-1:0] quotient,
	output logic [oaa_pkg::DIV_W-1:0] remainder
);

	localparam int DW = oaa_pkg::DIV_W;
	localparam int CNT_W = $clog2(DW);

	logic [DW-1:0] quo_q, rem_q, den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DW:0] shf, dif;
	logic ge;

	assign shf = {rem_q, quo_q[DW-1]};
	assign dif = shf - {1'b0, den_q};
	assign ge = (shf >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? dif[DW-1:0] : shf[DW-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/oaa_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial square root
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module oaa_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);

	localparam int CNT_W = $clog2(oaa_pkg::ROOT_STEPS);

	logic [63:0] v_q, res_q, bit_q, trial;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic ge;

	assign trial = res_q + bit_q;
	assign ge = (v_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(oaa_pkg::ROOT_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			v_q <= ge ? v_q - trial : v_q;
			res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// ===== rtl/core/oaa_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product, one multiplier bit per cycle, kept modulo 2^64.
// ----------------------------------------------------------------------------
module oaa_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [oaa_pkg::MUL_W-1:0] a,
	input  logic [oaa_pkg::MUL_W-1:0] b,
	output logic                      done,
	output logic [63:0]               product
);

	localparam int MW = oaa_pkg::MUL_W;
	localparam int CNT_W = $clog2(MW);

	logic [63:0] a_q, acc_q;
	logic [MW-1:0] b_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(MW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= 64'(a);
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (b_q[0] ? a_q : 64'd0);
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/core/oaa_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Folds a Q9.16 degree angle into the range -90 to +90 degrees, converts it to Q2.30
// radians and rotates one CORDIC iteration per cycle.
// ----------------------------------------------------------------------------
module oaa_cordic #(
	parameter int STEPS = oaa_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [oaa_pkg::ANG_W-1:0]    angle,
	output logic                                done,
	output logic signed [oaa_pkg::CW-1:0]       sine,
	output logic signed [oaa_pkg::CW-1:0]       cosine
);

	localparam int CW = oaa_pkg::CW;
	localparam int ZW = oaa_pkg::ZW;
	localparam int N = (STEPS > 32) ? 32 : STEPS;

	oaa_pkg::cdc_phase_t phase_q, phase_d;
	logic done_q, last, ld_fold, ld_init, rot;

	logic signed [26:0] a0, a1, a2, a3, deg_q, dmag;
	logic fl, flip_q;
	logic [47:0] zprod;
	logic [31:0] zmag;
	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, at;
	logic [4:0] i_q;

	assign last = (i_q == 5'(N - 1));

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			oaa_pkg::CP_IDLE:  if (start) phase_d = oaa_pkg::CP_SCALE;
			oaa_pkg::CP_SCALE: phase_d = oaa_pkg::CP_ROT;
			oaa_pkg::CP_ROT:   if (last) phase_d = oaa_pkg::CP_IDLE;
			default:           phase_d = oaa_pkg::CP_IDLE;
		endcase
	end

	always_comb begin
		ld_fold = 1'b0;
		ld_init = 1'b0;
		rot = 1'b0;
		case (phase_q)
			oaa_pkg::CP_IDLE:  ld_fold = start;
			oaa_pkg::CP_SCALE: ld_init = 1'b1;
			oaa_pkg::CP_ROT:   rot = 1'b1;
			default:           rot = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= oaa_pkg::CP_IDLE;
			done_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q <= rot && last;
		end
	end

	always_comb begin
		a0 = 27'(angle);
		if (a0 >= oaa_pkg::FULL_DEG) a1 = a0 - oaa_pkg::FULL_DEG;
		else if (a0 <= -oaa_pkg::FULL_DEG) a1 = a0 + oaa_pkg::FULL_DEG;
		else a1 = a0;
		if (a1 > oaa_pkg::HALF_DEG) a2 = a1 - oaa_pkg::FULL_DEG;
		else if (a1 < -oaa_pkg::HALF_DEG) a2 = a1 + oaa_pkg::FULL_DEG;
		else a2 = a1;
		fl = 1'b0;
		if (a2 > oaa_pkg::QUARTER_DEG) begin
			a3 = oaa_pkg::HALF_DEG - a2;
			fl = 1'b1;
		end else if (a2 < -oaa_pkg::QUARTER_DEG) begin
			a3 = -oaa_pkg::HALF_DEG - a2;
			fl = 1'b1;
		end else begin
			a3 = a2;
		end
	end

	assign dmag = deg_q[26] ? -deg_q : deg_q;
	assign zprod = 48'(dmag[22:0]) * oaa_pkg::DEG_TO_RAD_Q30;
	assign zmag = zprod[47:16];
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = ZW'(oaa_pkg::atan_q30(i_q));

	always_ff @(posedge clk) begin
		if (ld_fold) begin
			deg_q <= a3;
			flip_q <= fl;
		end
		if (ld_init) begin
			x_q <= oaa_pkg::CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= deg_q[26] ? -ZW'(zmag) : ZW'(zmag);
			i_q <= '0;
		end else if (rot) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			i_q <= i_q + 1'b1;
		end
	end

	assign done = done_q;
	assign sine = y_q;
	assign cosine = flip_q ? -x_q : x_q;

endmodule

// ===== tb/orbit_angle_advance_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit angle advance core testbench
// Drives time step requests through the core under several axis and rate
// settings, including the extremes, and compares every new angle with a
// bit-exact fixed-point model of the angle update kept in a scoreboard.
// ----------------------------------------------------------------------------
module orbit_angle_advance_core_tb;

	localparam logic [oaa_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam longint FULL_Q16 = 360 * 65536;
	localparam longint HALF_Q16 = 180 * 65536;
	localparam longint QUART_Q16 = 90 * 65536;
	localparam longint RAD_PER_DEG = 18740330;
	localparam longint GAIN_Q30 = 652032874;
	localparam int CYCLE_LIMIT = 1500000;

	class angle_scoreboard;
		bit [31:0] major_r, minor_r, rate_r;
		bit [oaa_pkg::ANG_W-1:0] angle_r;
		bit [oaa_pkg::ANG_W-1:0] due[$];
		int errors;
		longint atn[16];

		function new();
			atn = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
				16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
				131072, 65536, 32768};
			major_r = 65536;
			minor_r = 65536;
			rate_r = 0;
			angle_r = 0;
			errors = 0;
		endfunction

		function bit [63:0] isqrt(bit [63:0] v);
			bit [63:0] res, bt;
			res = 0;
			bt = 64'd1 << 62;
			for (int k = 0; k < 32; k++) begin
				if (v >= res + bt) begin
					v = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			return res;
		endfunction

		function void set_reg(bit [oaa_pkg::IDX_W-1:0] idx, bit [31:0] v);
			case (idx)
				oaa_pkg::CFG_MAJOR: major_r = v;
				oaa_pkg::CFG_MINOR: minor_r = v;
				oaa_pkg::CFG_RATE:  rate_r = v;
				default: ;
			endcase
		endfunction

		function void note_request(bit [oaa_pkg::DT_W-1:0] dt);
			longint ang, rate, deg, z, x, y, nx, s, c, t, th, sh, sum, res;
			bit [63:0] r, f, sq, d, g, p, step, mag;
			bit flip;
			ang = longint'(signed'(angle_r));
			rate = longint'(signed'(rate_r));
			if (minor_r == 0) begin
				r = 64'd1 << 16;
			end else begin
				r = (64'(major_r) << 16) / 64'(minor_r);
				if (r > (64'd255 << 16)) r = 64'd255 << 16;
			end
			f = (r * r > (64'd1 << 32)) ? isqrt(r * r - (64'd1 << 32)) : 64'd0;
			flip = 0;
			deg = ang % FULL_Q16;
			if (deg > HALF_Q16) deg -= FULL_Q16;
			if (deg < -HALF_Q16) deg += FULL_Q16;
			if (deg > QUART_Q16) begin
				deg = HALF_Q16 - deg;
				flip = 1;
			end
			if (deg < -QUART_Q16) begin
				deg = -HALF_Q16 - deg;
				flip = 1;
			end
			mag = (deg < 0) ? -deg : deg;
			z = longint'((mag * RAD_PER_DEG) >> 16);
			if (deg < 0) z = -z;
			x = GAIN_Q30;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= atn[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += atn[i];
				end
				x = nx;
			end
			if (flip) x = -x;
			s = y >>> 14;
			c = x >>> 14;
			t = ((longint'(r) * c) >>> 16) + longint'(f);
			th = t >>> 1;
			sh = s >>> 1;
			if (th < 0) th = -th;
			if (sh < 0) sh = -sh;
			sq = 64'(th * th) + 64'(sh * sh);
			d = isqrt(sq) << 1;
			if (d == 0) d = 1;
			g = isqrt(d << 16);
			p = 64'((rate < 0) ? -rate : rate) * 64'(dt);
			step = p / g;
			sum = ang + ((rate < 0) ? -longint'(step) : longint'(step));
			res = sum % FULL_Q16;
			angle_r = res[oaa_pkg::ANG_W-1:0];
			due.push_back(angle_r);
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_result(bit [oaa_pkg::ANG_W-1:0] got);
			bit [oaa_pkg::ANG_W-1:0] want;
			if (due.size() == 0) begin
				report($sformatf("new_angle %0d with no request waiting", signed'(got)));
			end else begin
				want = due.pop_front();
				if (got !== want)
					report($sformatf("new_angle %0d, expected %0d",
						signed'(got), signed'(want)));
			end
		endtask
	endclass

	logic clk, arst_n;
	logic cfg_write;
	logic [oaa_pkg::IDX_W-1:0] cfg_index;
	logic [oaa_pkg::CFG_W-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [oaa_pkg::DT_W-1:0] time_step;
	logic signed [oaa_pkg::ANG_W-1:0] new_angle;

	angle_scoreboard sb;
	int rx_hold;
	int cycles = 0;

	orbit_angle_advance_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .time_step(time_step),
		.out_valid(out_valid), .out_ready(out_ready), .new_angle(new_angle)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task write_reg(logic [oaa_pkg::IDX_W-1:0] idx, logic [oaa_pkg::CFG_W-1:0] v);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task wait_drained();
		in_valid <= 0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task load_cfg(logic [31:0] ma, logic [31:0] mi, logic [31:0] ra);
		wait_drained();
		write_reg(oaa_pkg::CFG_MAJOR, ma);
		write_reg(oaa_pkg::CFG_MINOR, mi);
		write_reg(oaa_pkg::CFG_RATE, ra);
		write_reg(CFG_SPARE, $urandom);
		cfg_write <= 0;
	endtask

	task send_step(logic [oaa_pkg::DT_W-1:0] dt);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		time_step <= dt;
		do @(posedge clk); while (!in_ready);
		sb.note_request(dt);
	endtask

	function automatic logic [31:0] pick_axis();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'hFFFFFFFF;
			default: return $urandom_range(1, 32'h40000);
		endcase
	endfunction

	initial begin
		int wait_n;
		out_ready = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			wait_n = rx_hold > 0 ? rx_hold : $urandom_range(0, 8);
			rx_hold = 0;
			if (wait_n > 0) begin
				out_ready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(new_angle);
		end
	end

	initial begin
		sb = new();
		arst_n = 0;
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		time_step = '0;
		rx_hold = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset values first, then the directed corners.
		send_step(24'hFFFFFF);
		load_cfg(32'd0, 32'h10000, 32'h7FFFFFFF);
		send_step(24'd0);
		send_step(24'd1);
		send_step(24'hFFFFFF);
		load_cfg($urandom, 32'd0, 32'h80000000);
		send_step(24'hFFFFFF);
		send_step(24'h800000);
		send_step(24'd1);
		load_cfg(32'hFFFFFFFF, 32'd1, 32'h7FFFFFFF);
		send_step(24'hFFFFFF);
		send_step(24'hAAAAAA);
		send_step(24'h555555);
		load_cfg(32'h8000, 32'h10000, 32'hFFFFFFFF);
		send_step(24'h000100);
		send_step(24'hFFFFFF);
		load_cfg(32'd1, 32'hFFFFFFFF, 32'h7FFFFFFF);
		send_step(24'h123456);
		send_step(24'hFFFFFF);
		load_cfg(32'h10000, 32'h10000, 32'h00010000);
		send_step(24'h010000);
		send_step(24'hFFFFFF);
		load_cfg(32'h30000, 32'h10000, 32'hFFF00000);
		send_step(24'hFFFFFF);
		send_step(24'h7FFFFF);

		for (int ph = 0; ph < 16; ph++) begin
			load_cfg(pick_axis(), pick_axis(),
				$urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 32'h3FFFFF)) -
				32'h200000);
			if (ph == 3) rx_hold = 2000;
			for (int i = 0; i < 27; i++) begin
				if (ph == 5 && i == 12) begin
					in_valid <= 0;
					while (sb.due.size() != 0) @(posedge clk);
				end
				send_step(24'($urandom_range(0, 3) == 0 ? $urandom :
					$urandom_range(0, 24'h3FFFF)));
			end
		end

		in_valid <= 0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
